// ===== rtl/core/packet_reorder_buffer_assert.svh =====
// Assertion macros shared by the reorder buffer RTL.
`ifndef PACKET_REORDER_BUFFER_ASSERT_SVH
`define PACKET_REORDER_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prb: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define PRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prb: next-cycle check failed");

`endif

// ===== rtl/core/prb_pkg.sv =====
package prb_pkg;

    localparam int SEQ_W     = 32;
    localparam int PAYLOAD_W = 16;

    typedef enum logic {
        KIND_RECEIPT  = 1'b0,
        KIND_DELIVERY = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_DELIVERED = 2'd0,
        ST_STORED    = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_BEYOND    = 2'd3
    } t_status;

    typedef struct packed {
        logic [SEQ_W-1:0]     sequence_number;
        logic [PAYLOAD_W-1:0] payload_handle;
    } t_item;

    typedef struct packed {
        t_kind                result_kind;
        logic [SEQ_W-1:0]     result_sequence;
        logic [PAYLOAD_W-1:0] result_payload;
        t_status              arrival_status;
        logic                 last_result;
    } t_result;

endpackage

// ===== rtl/core/prb_ram.sv =====
module prb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== rtl/core/prb_mod_unit.sv =====
module prb_mod_unit #(
    parameter int WINDOW = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [prb_pkg::SEQ_W-1:0] i_dividend,
    output logic                      o_done,
    output logic [$clog2(WINDOW)-1:0] o_rem
);
    import prb_pkg::*;

    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int DIGIT_W = SEQ_W / 2;
    localparam int SHIFT   = SEQ_W + SLOT_W;
    localparam int RECIP_W = SEQ_W + 2;
    localparam int PROD_W  = DIGIT_W + RECIP_W;
    localparam int ACC_W   = SEQ_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [SLOT_W-1:0]  W_LOW = SLOT_W'(WINDOW);

    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_HIGH = 4'b0010,
        P_LOW  = 4'b0100,
        P_REM  = 4'b1000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic               r_done, n_done;
    logic [SEQ_W-1:0]   r_dividend, n_dividend;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [SLOT_W-1:0]  r_rem, n_rem;
    logic [DIGIT_W-1:0] digit;
    logic [PROD_W-1:0]  prod;
    logic [ACC_W-1:0]   mac;
    logic [SLOT_W-1:0]  q_low;
    logic [SLOT_W-1:0]  q_times_w;

    // The quotient is the dividend times a rounded-up reciprocal, shifted down. The shared
    // multiplier takes the high half of the dividend first, then the low half.
    assign digit = (r_phase == P_HIGH) ? r_dividend[SEQ_W-1 -: DIGIT_W]
                                       : r_dividend[DIGIT_W-1:0];
    assign prod  = PROD_W'(digit) * PROD_W'(RECIP);
    assign mac   = {r_acc[ACC_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + ACC_W'(prod);

    // The remainder is below WINDOW, so the low bits of the quotient are enough.
    assign q_low     = r_acc[SHIFT +: SLOT_W];
    assign q_times_w = q_low * W_LOW;

    always_comb begin
        n_phase    = r_phase;
        n_done     = 1'b0;
        n_dividend = r_dividend;
        n_acc      = r_acc;
        n_rem      = r_rem;
        unique case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    n_dividend = i_dividend;
                    n_acc      = '0;
                    n_phase    = P_HIGH;
                end
            end
            P_HIGH: begin
                n_acc   = mac;
                n_phase = P_LOW;
            end
            P_LOW: begin
                n_acc   = mac;
                n_phase = P_REM;
            end
            P_REM: begin
                n_rem   = r_dividend[SLOT_W-1:0] - q_times_w;
                n_done  = 1'b1;
                n_phase = P_IDLE;
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dividend <= n_dividend;
        r_acc      <= n_acc;
        r_rem      <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/core/packet_reorder_buffer.sv =====
// Reorders numbered packets for in-order delivery. A transaction is taken when start is
// high and busy is low; busy then stays high until the last result of that packet has
// been shown. Every packet first yields a receipt with its arrival status; an in-order
// packet then yields one delivery per cycle for itself and for each stored successor.
// Results appear for exactly one cycle under o_strobe, and the receiver cannot stall them.
// When WINDOW is a power of two the receipt is shown in the cycle after acceptance.
// Otherwise the slot index is found by a shared reciprocal multiplier that takes half of
// the sequence number per cycle, and the receipt is shown once the divider has reported
// its remainder and the state machine has moved from S_MOD to S_CHECK. Stored handles are
// read through the single read port of the handle memory. Slot valid bits are cleared by
// reset at once, so no clearing pass follows reset.
`include "packet_reorder_buffer_assert.svh"

module packet_reorder_buffer #(
    parameter int WINDOW       = 16,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  prb_pkg::t_item   i_item,
    output logic             busy,
    output logic             o_strobe,
    output prb_pkg::t_result o_result
);
    import prb_pkg::*;

    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int HW      = (HANDLE_WIDTH < PAYLOAD_W) ? HANDLE_WIDTH : PAYLOAD_W;
    localparam bit IS_POW2 = ((WINDOW & (WINDOW - 1)) == 0);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MOD   = 4'b0010,
        S_CHECK = 4'b0100,
        S_DELIV = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [SEQ_W-1:0]  r_expected, n_expected;
    logic [WINDOW-1:0] r_slot_valid, n_slot_valid;
    logic              r_use_ram, n_use_ram;
    logic [SEQ_W-1:0]  r_seq, n_seq;
    logic [HW-1:0]     r_handle, n_handle;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SEQ_W-1:0]  r_cur, n_cur;
    logic [SLOT_W-1:0] r_next_slot, n_next_slot;

    logic              accept;
    logic              mod_done;
    logic [SLOT_W-1:0] mod_rem;
    logic [SEQ_W-1:0]  seq_gap;
    logic              more;
    t_status           status;
    logic              ram_we;
    logic              ram_re;
    logic [HW-1:0]     ram_rdata;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
                                                   input logic wrap32);
        logic [SLOT_W-1:0] res;
        if (wrap32 || s == SLOT_W'(WINDOW - 1)) begin
            res = '0;
        end else begin
            res = s + 1'b1;
        end
        return res;
    endfunction

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    prb_mod_unit #(
        .WINDOW (WINDOW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && !IS_POW2),
        .i_dividend (i_item.sequence_number),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    prb_ram #(
        .WIDTH (HW),
        .DEPTH (WINDOW)
    ) u_handle_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_handle),
        .i_re    (ram_re),
        .i_raddr (r_next_slot),
        .o_rdata (ram_rdata)
    );

    assign seq_gap = r_seq - r_expected;
    assign more    = r_slot_valid[r_next_slot];

    always_comb begin
        priority if (r_seq == r_expected) begin
            status = ST_DELIVERED;
        end else if (r_seq < r_expected || r_slot_valid[r_slot]) begin
            status = ST_DUPLICATE;
        end else if (seq_gap >= SEQ_W'(WINDOW)) begin
            status = ST_BEYOND;
        end else begin
            status = ST_STORED;
        end
    end

    always_comb begin
        o_strobe = 1'b0;
        o_result = '0;
        if (r_state == S_CHECK) begin
            o_strobe                 = 1'b1;
            o_result.result_kind     = KIND_RECEIPT;
            o_result.result_sequence = r_seq;
            o_result.arrival_status  = status;
            o_result.last_result     = (status != ST_DELIVERED);
        end else if (r_state == S_DELIV) begin
            o_strobe                 = 1'b1;
            o_result.result_kind     = KIND_DELIVERY;
            o_result.result_sequence = r_cur;
            o_result.result_payload  = r_use_ram ? PAYLOAD_W'(ram_rdata)
                                                 : PAYLOAD_W'(r_handle);
            o_result.arrival_status  = ST_DELIVERED;
            o_result.last_result     = !more;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_expected   = r_expected;
        n_slot_valid = r_slot_valid;
        n_use_ram    = r_use_ram;
        n_seq        = r_seq;
        n_handle     = r_handle;
        n_slot       = r_slot;
        n_cur        = r_cur;
        n_next_slot  = r_next_slot;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_seq    = i_item.sequence_number;
                    n_handle = i_item.payload_handle[HW-1:0];
                    n_slot   = i_item.sequence_number[SLOT_W-1:0];
                    n_state  = IS_POW2 ? S_CHECK : S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_slot  = mod_rem;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_IDLE;
                unique case (status)
                    ST_DELIVERED: begin
                        n_expected  = r_seq + 1'b1;
                        n_cur       = r_seq;
                        n_use_ram   = 1'b0;
                        n_next_slot = slot_inc(r_slot, &r_seq);
                        n_state     = S_DELIV;
                    end
                    ST_STORED: begin
                        n_slot_valid[r_slot] = 1'b1;
                        ram_we               = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_DELIV: begin
                if (more) begin
                    // Fetch the successor's handle; it is shown in the next cycle.
                    ram_re                    = 1'b1;
                    n_slot_valid[r_next_slot] = 1'b0;
                    n_cur                     = r_expected;
                    n_expected                = r_expected + 1'b1;
                    n_next_slot               = slot_inc(r_next_slot, &r_expected);
                    n_use_ram                 = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_expected   <= '0;
            r_slot_valid <= '0;
            r_use_ram    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_expected   <= n_expected;
            r_slot_valid <= n_slot_valid;
            r_use_ram    <= n_use_ram;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq       <= n_seq;
        r_handle    <= n_handle;
        r_slot      <= n_slot;
        r_cur       <= n_cur;
        r_next_slot <= n_next_slot;
    end

    `PRB_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
    `PRB_ASSERT_NXT(a_last_idle, i_clk, i_rst_n, o_strobe && o_result.last_result, !busy)
    `PRB_ASSERT_IMP(a_drain_expected, i_clk, i_rst_n, r_state == S_DELIV, r_expected == r_cur + 1'b1)
    `PRB_ASSERT_IMP(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy)

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prb_pkg::*;

    localparam int WINDOW       = 16;
    localparam int HANDLE_WIDTH = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    class reorder_scoreboard;
        logic [SEQ_W-1:0]     next_in_order;
        logic                 slot_full [WINDOW];
        logic [PAYLOAD_W-1:0] slot_payload [WINDOW];
        t_result              awaited_results [$];
        int                   error_count;

        function new();
            next_in_order = '0;
            foreach (slot_full[i]) slot_full[i] = 1'b0;
            foreach (slot_payload[i]) slot_payload[i] = '0;
            error_count = 0;
        endfunction

        function void push_result(t_kind kind, logic [SEQ_W-1:0] seq,
                                  logic [PAYLOAD_W-1:0] payload, t_status status,
                                  logic last);
            t_result r;
            r.result_kind     = kind;
            r.result_sequence = seq;
            r.result_payload  = payload;
            r.arrival_status  = status;
            r.last_result     = last;
            awaited_results = {awaited_results, r};
        endfunction

        // Works out every result that one accepted packet causes.
        function void note_packet(t_item pkt);
            logic [SEQ_W-1:0]     seq;
            logic [PAYLOAD_W-1:0] handle;
            logic [SEQ_W-1:0]     seq_gap;
            int unsigned          slot;
            int unsigned          nxt;
            t_status              status;
            logic                 more;
            logic [SEQ_W-1:0]     cur;
            logic [PAYLOAD_W-1:0] cur_handle;
            seq     = pkt.sequence_number;
            handle  = pkt.payload_handle & PAYLOAD_W'((64'd1 << HANDLE_WIDTH) - 1);
            slot    = seq % WINDOW;
            seq_gap = seq - next_in_order;
            if (seq == next_in_order)
                status = ST_DELIVERED;
            else if (seq < next_in_order || slot_full[slot])
                status = ST_DUPLICATE;
            else if (seq_gap >= WINDOW)
                status = ST_BEYOND;
            else
                status = ST_STORED;
            push_result(KIND_RECEIPT, seq, '0, status, status != ST_DELIVERED);
            if (status == ST_STORED) begin
                slot_full[slot]    = 1'b1;
                slot_payload[slot] = handle;
            end else if (status == ST_DELIVERED) begin
                cur           = seq;
                cur_handle    = handle;
                next_in_order = seq + 1'b1;
                for (int i = 0; i < WINDOW; i++) begin
                    nxt  = next_in_order % WINDOW;
                    more = slot_full[nxt];
                    push_result(KIND_DELIVERY, cur, cur_handle, ST_DELIVERED, !more);
                    if (!more) break;
                    cur            = next_in_order;
                    cur_handle     = slot_payload[nxt];
                    slot_full[nxt] = 1'b0;
                    next_in_order  = next_in_order + 1'b1;
                end
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                $error("unexpected result: sequence %0h kind %0d",
                       got.result_sequence, got.result_kind);
                error_count++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.result_kind !== want.result_kind) begin
                $error("result_kind: expected %0d, actual %0d",
                       want.result_kind, got.result_kind);
                error_count++;
            end
            if (got.result_sequence !== want.result_sequence) begin
                $error("result_sequence: expected %0h, actual %0h",
                       want.result_sequence, got.result_sequence);
                error_count++;
            end
            if (got.result_payload !== want.result_payload) begin
                $error("result_payload: expected %0h, actual %0h",
                       want.result_payload, got.result_payload);
                error_count++;
            end
            if (got.arrival_status !== want.arrival_status) begin
                $error("arrival_status: expected %0d, actual %0d",
                       want.arrival_status, got.arrival_status);
                error_count++;
            end
            if (got.last_result !== want.last_result) begin
                $error("last_result: expected %0d, actual %0d",
                       want.last_result, got.last_result);
                error_count++;
            end
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_strobe;
    t_result o_result;
    int      cycle_count;

    reorder_scoreboard sb = new();

    packet_reorder_buffer #(
        .WINDOW       (WINDOW),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1)
            sb.check_result(o_result);
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_packet(input logic [SEQ_W-1:0] seq,
                               input logic [PAYLOAD_W-1:0] handle, input int idle_pct);
        t_item pkt;
        pkt.sequence_number = seq;
        pkt.payload_handle  = handle;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= pkt;
        do @(posedge i_clk); while (busy);
        sb.note_packet(pkt);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (sb.awaited_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [PAYLOAD_W-1:0] pick_handle();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return PAYLOAD_W'($urandom);
    endfunction

    // Mostly numbers near the next in-order one, so that packets get stored and
    // then drained; the rest are stale, far ahead or fully random numbers.
    function automatic logic [SEQ_W-1:0] pick_sequence();
        int unsigned      r;
        logic [SEQ_W-1:0] base;
        base = sb.next_in_order;
        r    = $urandom_range(0, 99);
        if (r < 60)
            return base + $urandom_range(1, WINDOW - 1);
        if (r < 75)
            return base;
        if (r < 85)
            return base + $urandom_range(WINDOW, 3 * WINDOW);
        if (r < 93) begin
            if (base >= 20) return base - $urandom_range(1, 20);
            return base + $urandom_range(0, WINDOW - 1);
        end
        return $urandom;
    endfunction

    task automatic run_random(input int count, input int idle_pct);
        for (int i = 0; i < count; i++)
            send_packet(pick_sequence(), pick_handle(), idle_pct);
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // In-order arrival, then a stale copy of it.
        send_packet(32'd0, 16'h0000, 32);
        send_packet(32'd0, 16'h1234, 32);
        // Out of order, a copy of a stored one, then the gap filler drains three.
        send_packet(32'd3, 16'hFFFF, 32);
        send_packet(32'd3, 16'h5555, 32);
        send_packet(32'd2, 16'hAAAA, 32);
        send_packet(32'd1, 16'h0001, 32);
        // Window edges: one past the last slot is dropped, the last slot is kept.
        send_packet(32'd20, 16'h00FF, 32);
        send_packet(32'd19, 16'hFF00, 32);
        send_packet(32'hFFFF_FFFF, 16'hFFFF, 32);
        // Fill every remaining slot, then the missing packet releases a full drain.
        for (int s = 5; s <= 18; s++)
            send_packet(SEQ_W'(s), PAYLOAD_W'(16'h8000 | (s << 4)), 32);
        send_packet(32'd4, 16'h7FFF, 32);
        wait_drained();

        run_random(140, 32);
        wait_drained();
        run_random(140, 71);
        wait_drained();
        run_random(140, 0);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.awaited_results.size() != 0) begin
            $error("%0d results never arrived", sb.awaited_results.size());
            sb.error_count++;
        end
        if (sb.error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
